@@ rtl/utf8_encoding_detector_macros.svh @@
// Assertion macros shared by the UTF-8 detector checks.
`ifndef UTF8_ENCODING_DETECTOR_MACROS_SVH
`define UTF8_ENCODING_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define U8D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8d check failed (same cycle)");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define U8D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8d check failed (next cycle)");

`endif

@@ rtl/u8d_pkg.sv @@
// Types, byte constants and decode helpers for the UTF-8 detector.
`timescale 1ns / 1ps
`default_nettype none
package u8d_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] cont_t;
  typedef logic [1:0] pos_t;
  typedef logic [2:0] cls_t;

  // Allowed range for the next continuation byte
  localparam cls_t CLS_ANY = 3'd0;  // 80-BF
  localparam cls_t CLS_E0  = 3'd1;  // A0-BF
  localparam cls_t CLS_ED  = 3'd2;  // 80-9F
  localparam cls_t CLS_F0  = 3'd3;  // 90-BF
  localparam cls_t CLS_F4  = 3'd4;  // 80-8F

  localparam byte_t LEAD2_LO = 8'hC2;
  localparam byte_t LEAD2_HI = 8'hDF;
  localparam byte_t LEAD3_LO = 8'hE0;
  localparam byte_t LEAD3_HI = 8'hEF;
  localparam byte_t LEAD_ED  = 8'hED;
  localparam byte_t LEAD4_LO = 8'hF0;
  localparam byte_t LEAD4_HI = 8'hF4;
  localparam byte_t CONT_LO  = 8'h80;
  localparam byte_t CONT_HI  = 8'hBF;
  localparam byte_t E0_LO    = 8'hA0;
  localparam byte_t ED_HI    = 8'h9F;
  localparam byte_t F0_LO    = 8'h90;
  localparam byte_t F4_HI    = 8'h8F;

  localparam byte_t BOM_0 = 8'hEF;
  localparam byte_t BOM_1 = 8'hBB;
  localparam byte_t BOM_2 = 8'hBF;

  localparam pos_t POS_SAT = 2'd3;

  typedef struct packed {
    cont_t cont;      // continuation bytes still expected
    cls_t  cls;       // range for the next continuation
    pos_t  pos;       // bytes seen, saturating
    logic  bom_ok;    // prefix still matches EF BB BF
    logic  valid;     // no violation yet
    logic  high;      // a byte with bit 7 set was seen
  } track_t;

  localparam track_t TRACK_INIT = '{
    cont:   2'd0,
    cls:    CLS_ANY,
    pos:    2'd0,
    bom_ok: 1'b1,
    valid:  1'b1,
    high:   1'b0
  };

  function automatic byte_t mark_byte(input pos_t pos);
    byte_t m;
    unique case (pos)
      2'd0:    m = BOM_0;
      2'd1:    m = BOM_1;
      2'd2:    m = BOM_2;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic in_class(input byte_t b, input cls_t cls);
    logic ok;
    unique case (cls)
      CLS_E0:  ok = (b >= E0_LO)   && (b <= CONT_HI);
      CLS_ED:  ok = (b >= CONT_LO) && (b <= ED_HI);
      CLS_F0:  ok = (b >= F0_LO)   && (b <= CONT_HI);
      CLS_F4:  ok = (b >= CONT_LO) && (b <= F4_HI);
      default: ok = (b >= CONT_LO) && (b <= CONT_HI);
    endcase
    return ok;
  endfunction

endpackage
`default_nettype wire

@@ rtl/u8d_if.sv @@
// Valid/ready channel interfaces for the detector's byte input and verdict output.
`timescale 1ns / 1ps
`default_nettype none
interface u8d_in_if import u8d_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*; ();
  logic valid;
  logic ready;
  logic is_utf8;
  logic bom_found;
  logic well_formed;
  logic high_seen;

  modport source (output valid, output is_utf8, output bom_found, output well_formed,
                  output high_seen, input ready);
  modport sink   (input valid, input is_utf8, input bom_found, input well_formed,
                  input high_seen, output ready);
endinterface
`default_nettype wire

@@ rtl/utf8_encoding_detector.sv @@
// UTF-8 encoding detector: top level with byte input stage and verdict register.
//
// Usage:
//  - in_chan carries one file byte per item (data_byte) with final_byte set on
//    the last byte of the file. Every file is at least one byte long.
//  - out_chan carries one verdict item per file, produced by its last byte:
//    is_utf8 = bom_found | (well_formed & high_seen), plus the three flags.
//  - Non-final bytes produce no output item; they only update tracking state.
// Timing:
//  - One byte per cycle sustained. An accepted byte sits in the input register
//    while the tracking update runs on it; the verdict for the last byte is
//    then written to the verdict register and shown on out_chan.
//  - The only limit on rate is the single verdict register: a final byte
//    waits in the input stage while an earlier verdict is still unread.
// Reset (rst_n low, synchronous): both stages empty, tracking state back to
//  its start value (no BOM mismatch, valid, no high byte seen).
// Stall: while out_chan.ready is low the verdict holds; non-final bytes keep
//  flowing, and in_chan.ready drops only when a final byte is blocked behind it.
// After each verdict the tracking state clears, so the next file starts fresh.
`timescale 1ns / 1ps
`default_nettype none
module utf8_encoding_detector import u8d_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  u8d_in_if.sink     in_chan,
  u8d_out_if.source  out_chan
);

  // Input stage
  logic   s1_valid_r;
  byte_t  s1_byte_r;
  logic   s1_final_r;
  logic   s1_adv;
  logic   in_fire;

  // Tracking state
  track_t track_r;
  track_t track_nxt;

  // Verdict register
  logic   out_valid_r;
  logic   out_utf8_r;
  logic   out_bom_r;
  logic   out_wf_r;
  logic   out_high_r;

  logic   bom_v;
  logic   wf_v;

  // A non-final byte never needs output room; a final one needs the verdict
  // register empty or being read this cycle.
  assign s1_adv  = s1_valid_r && (!s1_final_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire = in_chan.valid && in_chan.ready;

  // Per-byte tracking update
  always_comb begin
    track_nxt = track_r;

    // BOM prefix match over the first three bytes
    if (track_r.pos != POS_SAT) begin
      if (s1_byte_r != mark_byte(track_r.pos)) begin
        track_nxt.bom_ok = 1'b0;
      end
      track_nxt.pos = track_r.pos + 2'd1;
    end

    if (s1_byte_r[7]) begin
      track_nxt.high = 1'b1;
    end

    // Strict UTF-8 check; frozen once a violation is seen
    if (track_r.valid) begin
      if (track_r.cont != 2'd0) begin
        track_nxt.cls = CLS_ANY;
        if (in_class(s1_byte_r, track_r.cls)) begin
          track_nxt.cont = track_r.cont - 2'd1;
        end else begin
          track_nxt.valid = 1'b0;
          track_nxt.cont  = 2'd0;
        end
      end else if (s1_byte_r[7]) begin
        if ((s1_byte_r >= LEAD2_LO) && (s1_byte_r <= LEAD2_HI)) begin
          track_nxt.cont = 2'd1;
          track_nxt.cls  = CLS_ANY;
        end else if ((s1_byte_r >= LEAD3_LO) && (s1_byte_r <= LEAD3_HI)) begin
          track_nxt.cont = 2'd2;
          track_nxt.cls  = (s1_byte_r == LEAD3_LO) ? CLS_E0 :
                           (s1_byte_r == LEAD_ED)  ? CLS_ED : CLS_ANY;
        end else if ((s1_byte_r >= LEAD4_LO) && (s1_byte_r <= LEAD4_HI)) begin
          track_nxt.cont = 2'd3;
          track_nxt.cls  = (s1_byte_r == LEAD4_LO) ? CLS_F0 :
                           (s1_byte_r == LEAD4_HI) ? CLS_F4 : CLS_ANY;
        end else begin
          // stray continuation, C0/C1, F5-FF
          track_nxt.valid = 1'b0;
        end
      end
    end
  end

  // Verdict as seen after this byte; truncated sequence fails well_formed
  assign bom_v = track_nxt.bom_ok && (track_nxt.pos == POS_SAT);
  assign wf_v  = track_nxt.valid && (track_nxt.cont == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_chan.data_byte;
      s1_final_r <= in_chan.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= TRACK_INIT;
    end else if (s1_adv) begin
      track_r <= s1_final_r ? TRACK_INIT : track_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_final_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_final_r) begin
      out_utf8_r <= bom_v || (wf_v && track_nxt.high);
      out_bom_r  <= bom_v;
      out_wf_r   <= wf_v;
      out_high_r <= track_nxt.high;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.is_utf8     = out_utf8_r;
  assign out_chan.bom_found   = out_bom_r;
  assign out_chan.well_formed = out_wf_r;
  assign out_chan.high_seen   = out_high_r;

endmodule
`default_nettype wire

@@ rtl/u8d_checker.sv @@
// Port-level checks for the UTF-8 detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_encoding_detector_macros.svh"
module u8d_checker (
  input wire clk,
  input wire rst_n,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire is_utf8,
  input wire bom_found,
  input wire well_formed,
  input wire high_seen
);

  // stalled verdict holds
  `U8D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({is_utf8, bom_found, well_formed, high_seen}))

  // verdict bit follows from the flags
  `U8D_ASSERT_NOW(a_verdict, out_valid, is_utf8 == (bom_found || (well_formed && high_seen)))

  // a BOM holds high bytes
  `U8D_ASSERT_NOW(a_bom_high, out_valid && bom_found, high_seen)

  // input backs up only behind a waiting verdict
  `U8D_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready)

endmodule

bind utf8_encoding_detector u8d_checker u_u8d_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .is_utf8     (out_chan.is_utf8),
  .bom_found   (out_chan.bom_found),
  .well_formed (out_chan.well_formed),
  .high_seen   (out_chan.high_seen)
);
`default_nettype wire
